// ===== hw/rtl/cbm_pkg.sv =====
// Shared types, constants and helpers for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Cartridge RAM geometry
    localparam int RAM_BANKS     = 4;
    localparam int RAM_BANK_AW   = 13;
    localparam int RAM_DEPTH     = RAM_BANKS * (1 << RAM_BANK_AW);
    localparam int RAM_AW        = $clog2(RAM_DEPTH);

    // ROM geometry
    localparam int ROM_BANK_BITS = 7;
    localparam int ROM_BANK_AW   = 14;
    localparam int ROM_AW        = 21;

    // Bus field widths
    localparam int BUS_AW        = 16;
    localparam int DATA_W        = 8;

    // Address regions, decoded on the top three address bits (8 KiB windows)
    localparam logic [2:0] REGION_RAM_ENABLE = 3'(16'h0000 >> RAM_BANK_AW);
    localparam logic [2:0] REGION_ROM_LOW    = 3'(16'h2000 >> RAM_BANK_AW);
    localparam logic [2:0] REGION_ROM_HIGH   = 3'(16'h4000 >> RAM_BANK_AW);
    localparam logic [2:0] REGION_MODE       = 3'(16'h6000 >> RAM_BANK_AW);
    localparam logic [2:0] REGION_CART_RAM   = 3'(16'hA000 >> RAM_BANK_AW);

    // Lower bank field
    localparam logic [4:0] ROM_LOW_MASK = 5'h1F;

    // Access kind on the input channel
    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // Kind of result on the output channel
    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_NONE = 2'd2
    } target_t;

    // Decoded access, handed from the bank register block to the datapath
    typedef struct packed {
        logic                ram_we;
        logic [RAM_AW-1:0]   ram_addr;
        target_t             target;
        logic [ROM_AW-1:0]   rom_address;
    } dec_t;

    // RAM bank number modulo the bank count (two-bit value, few steps)
    function automatic logic [1:0] ram_bank_mod(input logic [1:0] bank);
        logic [1:0] b;
        b = bank;
        for (int i = 0; i < 3; i++) begin
            if ({1'b0, b} >= 3'(RAM_BANKS)) begin
                b = b - 2'(RAM_BANKS);
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbm_regs.sv =====
// Bank control registers and address decode of the cartridge bank mapper.
`default_nettype none

module cbm_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       accept,
    input  wire cbm_pkg::cmd_t              command,
    input  wire logic [cbm_pkg::BUS_AW-1:0] bus_address,
    input  wire logic [cbm_pkg::DATA_W-1:0] write_data,
    output cbm_pkg::dec_t                   dec
);
    import cbm_pkg::*;

    logic [ROM_BANK_BITS-1:0] rom_bank_reg, rom_bank_next;
    logic [1:0]               ram_bank_reg, ram_bank_next;
    logic                     mode_reg, mode_next;
    logic                     ram_en_reg, ram_en_next;

    logic [2:0]               region;
    logic [6:0]               rom_bank_wide;
    logic [4:0]               low_field;
    logic [6:0]               rom_low_upd;
    logic [6:0]               rom_high_upd;
    logic                     is_write;

    assign region        = bus_address[BUS_AW-1 -: 3];
    assign is_write      = (command == CMD_WRITE);
    assign rom_bank_wide = 7'(rom_bank_reg);

    // Lower bank field: zero selects bank 1
    assign low_field    = (write_data[4:0] & ROM_LOW_MASK) == 5'd0 ?
                          5'd1 : (write_data[4:0] & ROM_LOW_MASK);
    assign rom_low_upd  = {rom_bank_wide[6:5], low_field};
    assign rom_high_upd = {write_data[1:0], rom_bank_wide[4:0]};

    // Register updates on accepted writes
    always_comb begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        mode_next     = mode_reg;
        ram_en_next   = ram_en_reg;
        if (accept && is_write) begin
            case (region)
                REGION_RAM_ENABLE: ram_en_next = (write_data != '0);
                REGION_ROM_LOW:    rom_bank_next = rom_low_upd[ROM_BANK_BITS-1:0];
                REGION_ROM_HIGH: begin
                    if (mode_reg) begin
                        ram_bank_next = write_data[1:0];
                    end else begin
                        rom_bank_next = rom_high_upd[ROM_BANK_BITS-1:0];
                    end
                end
                REGION_MODE:       mode_next = write_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg <= ROM_BANK_BITS'(1);
            ram_bank_reg <= 2'd0;
            mode_reg     <= 1'b0;
            ram_en_reg   <= 1'b0;
        end else begin
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
            mode_reg     <= mode_next;
            ram_en_reg   <= ram_en_next;
        end
    end

    // Decode of the access for the datapath
    always_comb begin
        dec.ram_addr    = RAM_AW'({ram_bank_mod(ram_bank_reg),
                                   bus_address[RAM_BANK_AW-1:0]});
        dec.ram_we      = accept && is_write && ram_en_reg &&
                          (region == REGION_CART_RAM);
        dec.target      = TGT_NONE;
        dec.rom_address = '0;
        if (!is_write) begin
            case (region)
                REGION_RAM_ENABLE, REGION_ROM_LOW: begin
                    dec.target      = TGT_ROM;
                    dec.rom_address = ROM_AW'(bus_address);
                end
                REGION_ROM_HIGH, REGION_MODE: begin
                    dec.target      = TGT_ROM;
                    dec.rom_address = {rom_bank_wide, bus_address[ROM_BANK_AW-1:0]};
                end
                REGION_CART_RAM:   dec.target = TGT_RAM;
                default:           dec.target = TGT_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cartridge_bank_mapper_core.sv =====
// Top level of the cartridge bank mapper: cartridge RAM and result pipeline.
//
// One CPU bus access enters per transaction on the s_ channel: s_tuser is
// the command (0 read, 1 write), s_tdata holds address and write byte.
// Every accepted access gives exactly one result transaction on the m_
// channel: m_tuser is the target (0 ROM address, 1 RAM data, 2 nothing or
// a write), m_tdata holds the physical ROM address and the RAM byte.
// Each result passes stage one (waiting on the RAM read) and then the output
// register. Throughput is one access per cycle while the receiver does not
// stall: bank register updates happen at acceptance and the cartridge RAM
// (one synchronous port, written and read at acceptance) serves each access
// at acceptance, so an access sees every earlier one.
// Reset (aresetn low, synchronous) sets ROM bank 1, RAM bank 0, ROM
// banking mode and RAM disabled, and empties the pipeline. Cartridge RAM
// contents are not cleared. When the receiver stalls, the output register
// holds its result and a second stage takes one more access; after that
// s_tready drops until the output drains.
`default_nettype none

module cartridge_bank_mapper_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_data
    input  wire logic        s_tuser,   // [0] command
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [20:0] rom_address, [28:21] read_data
    output logic [1:0]       m_tuser    // [1:0] target
);
    import cbm_pkg::*;

    logic                s_accept;
    dec_t                dec;

    logic [DATA_W-1:0]   bank_mem [0:RAM_DEPTH-1];
    logic [DATA_W-1:0]   ram_q_reg;

    logic                s1_valid_reg, s1_valid_next;
    target_t             s1_target_reg;
    logic [ROM_AW-1:0]   s1_rom_reg;

    logic                m_valid_reg, m_valid_next;
    target_t             m_target_reg;
    logic [ROM_AW-1:0]   m_rom_reg;
    logic [DATA_W-1:0]   m_rdata_reg;
    logic                m_load;

    assign m_load   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || m_load;
    assign s_accept = s_tvalid && s_tready;

    cbm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .command     (cmd_t'(s_tuser)),
        .bus_address (s_tdata[15:0]),
        .write_data  (s_tdata[23:16]),
        .dec         (dec)
    );

    // Cartridge RAM: one read per accepted access, plus a write for enabled RAM writes
    always_ff @(posedge aclk) begin
        if (dec.ram_we) begin
            bank_mem[dec.ram_addr] <= s_tdata[23:16];
        end
        if (s_accept) begin
            ram_q_reg <= bank_mem[dec.ram_addr];
        end
    end

    // Valid flags
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (m_load) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload: stage one waits on the RAM read, then the output register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_target_reg <= dec.target;
            s1_rom_reg    <= dec.rom_address;
        end
        if (m_load) begin
            m_target_reg <= s1_target_reg;
            m_rom_reg    <= s1_rom_reg;
            m_rdata_reg  <= (s1_target_reg == TGT_RAM) ? ram_q_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_target_reg;
    assign m_tdata  = {3'b000, m_rdata_reg, m_rom_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/cbm_checker.sv =====
// Port-level assertions for the cartridge bank mapper, bound to the top level.
`default_nettype none

module cbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import cbm_pkg::*;

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Target is a defined code
    a_target_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == TGT_ROM || m_tuser == TGT_RAM || m_tuser == TGT_NONE))
        else $error("undefined target code");

    // Data fields that do not belong to the target are zero
    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != TGT_RAM |-> m_tdata[28:21] == 8'd0)
        else $error("read data set for non-RAM target");

    a_rom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != TGT_ROM |-> m_tdata[20:0] == 21'd0)
        else $error("ROM address set for non-ROM target");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
